[hdl/mfcd_pkg.sv]
// Shared types, constants and the CRC byte update for the meter frame decoder.
// Used by mfcd_front, mfcd_queue, mfcd_back and meter_frame_crc_decoder_unit.
`default_nettype none

package mfcd_pkg;

   localparam logic [5:0]  FRAME_LAST       = 6'd36;
   localparam logic [5:0]  CRC_SPAN         = 6'd35;
   localparam logic [5:0]  VOLT_FIRST       = 6'd3;
   localparam logic [5:0]  VOLT_LAST        = 6'd6;
   localparam logic [5:0]  CURR_FIRST       = 6'd7;
   localparam logic [5:0]  CURR_LAST        = 6'd10;
   localparam logic [5:0]  POWER_FIRST      = 6'd11;
   localparam logic [5:0]  POWER_LAST       = 6'd14;
   localparam logic [5:0]  FREQ_FIRST       = 6'd31;
   localparam logic [5:0]  FREQ_LAST        = 6'd34;

   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;

   localparam logic [31:0] NOMINAL_RESET    = 32'd2200000;
   localparam logic [31:0] MAX_RESET        = 32'd0;
   localparam logic [31:0] MIN_RESET        = 32'd3800000;

   localparam logic [6:0]  SCALE            = 7'd100;
   localparam logic [31:0] RECIP_100        = 32'h51EB851F;
   localparam int          RECIP_SHIFT      = 37;

   localparam int          NUM_W            = 39;
   localparam logic [5:0]  DIV_LAST_STEP    = 6'd38;

   localparam int          QUEUE_DEPTH_DEF  = 2;

   typedef struct packed {
      logic        crc_ok;
      logic [31:0] voltage_word;
      logic [31:0] current_word;
      logic [31:0] power_word;
      logic [31:0] freq_word;
   } frame_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hdl/mfcd_front.sv]
// Front end: takes received bytes, runs the CRC and collects the frame words.
// Pushes one frame record per 37 bytes into the queue; depends on mfcd_pkg.
`default_nettype none

module mfcd_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [7:0]          req_rx_byte,
   input  wire                 queue_full,
   output logic                push,
   output mfcd_pkg::frame_type push_frame
);
   import mfcd_pkg::*;

   logic [5:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [31:0] volt_ff, volt_in;
   logic [31:0] curr_ff, curr_in;
   logic [31:0] power_ff, power_in;
   logic [31:0] freq_ff, freq_in;
   logic [7:0]  first_ff, first_in;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      volt_in    = volt_ff;
      curr_in    = curr_ff;
      power_in   = power_ff;
      freq_in    = freq_ff;
      first_in   = first_ff;
      push       = 1'b0;
      push_frame.crc_ok       = (first_ff == crc_ff[7:0]) && (req_rx_byte == crc_ff[15:8]);
      push_frame.voltage_word = volt_ff;
      push_frame.current_word = curr_ff;
      push_frame.power_word   = power_ff;
      push_frame.freq_word    = freq_ff;
      if (accept) begin
         if (count_ff < CRC_SPAN) begin
            crc_in = crc16_byte(crc_ff, req_rx_byte);
         end
         if (count_ff >= VOLT_FIRST && count_ff <= VOLT_LAST) begin
            volt_in = {volt_ff[23:0], req_rx_byte};
         end else if (count_ff >= CURR_FIRST && count_ff <= CURR_LAST) begin
            curr_in = {curr_ff[23:0], req_rx_byte};
         end else if (count_ff >= POWER_FIRST && count_ff <= POWER_LAST) begin
            power_in = {power_ff[23:0], req_rx_byte};
         end else if (count_ff >= FREQ_FIRST && count_ff <= FREQ_LAST) begin
            freq_in = {freq_ff[23:0], req_rx_byte};
         end else if (count_ff == CRC_SPAN) begin
            first_in = req_rx_byte;
         end
         if (count_ff == FRAME_LAST) begin
            count_in = '0;
            crc_in   = CRC_INIT;
            push     = 1'b1;
         end else begin
            count_in = count_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      volt_ff  <= volt_in;
      curr_ff  <= curr_in;
      power_ff <= power_in;
      freq_ff  <= freq_in;
      first_ff <= first_in;
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

`default_nettype wire

[hdl/mfcd_queue.sv]
// Short queue of frame records between front and back end.
// Depth set by DEPTH (at least 2); depends on mfcd_pkg for the record type.
`default_nettype none

module mfcd_queue #(
   parameter int DEPTH = mfcd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  mfcd_pkg::frame_type push_frame,
   output logic                full,
   input  wire                 pop,
   output mfcd_pkg::frame_type head,
   output logic                empty
);
   import mfcd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   frame_type         slot_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_frame;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[hdl/mfcd_back.sv]
// Back end: scales the frame words, divides for the deviation, tracks extremes.
// Holds the nominal voltage register and the result register; depends on mfcd_pkg.
`default_nettype none

module mfcd_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [31:0]         csr_wdata,
   input  wire                 queue_empty,
   input  mfcd_pkg::frame_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_crc_ok,
   output logic [15:0]         rsp_voltage,
   output logic [15:0]         rsp_current,
   output logic [31:0]         rsp_power_hundredths,
   output logic [15:0]         rsp_frequency,
   output logic [31:0]         rsp_deviation_percent,
   output logic [31:0]         rsp_voltage_max,
   output logic [31:0]         rsp_voltage_min
);
   import mfcd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SCALE, S_MUL, S_DIV, S_DONE} state_type;

   state_type         state_ff, state_in;
   frame_type         frame_ff, frame_in;
   logic [31:0]       nominal_ff, nominal_in;
   logic [31:0]       max_ff, max_in;
   logic [31:0]       min_ff, min_in;
   logic [31:0]       diff_ff, diff_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [31:0]       rem_ff, rem_in;
   logic [5:0]        step_ff, step_in;
   logic [63:0]       prod_ff, prod_in;
   logic [15:0]       vq_ff, vq_in;
   logic [15:0]       cq_ff, cq_in;
   logic [15:0]       fq_ff, fq_in;
   logic              valid_ff, valid_in;
   logic              ok_ff, ok_in;
   logic [15:0]       ov_ff, ov_in;
   logic [15:0]       oc_ff, oc_in;
   logic [31:0]       op_ff, op_in;
   logic [15:0]       of_ff, of_in;
   logic [31:0]       od_ff, od_in;
   logic [31:0]       omax_ff, omax_in;
   logic [31:0]       omin_ff, omin_in;
   logic [31:0]       scale_op;
   logic [32:0]       trial;
   logic              out_free;

   assign csr_ready             = 1'b1;
   assign rsp_valid             = valid_ff;
   assign rsp_crc_ok            = ok_ff;
   assign rsp_voltage           = ov_ff;
   assign rsp_current           = oc_ff;
   assign rsp_power_hundredths  = op_ff;
   assign rsp_frequency         = of_ff;
   assign rsp_deviation_percent = od_ff;
   assign rsp_voltage_max       = omax_ff;
   assign rsp_voltage_min       = omin_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign trial    = {rem_ff, num_ff[NUM_W-1]};

   always_comb begin
      case (step_ff)
         6'd0:    scale_op = frame_ff.voltage_word;
         6'd1:    scale_op = frame_ff.current_word;
         default: scale_op = frame_ff.freq_word;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      frame_in   = frame_ff;
      nominal_in = nominal_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      diff_in    = diff_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      prod_in    = prod_ff;
      vq_in      = vq_ff;
      cq_in      = cq_ff;
      fq_in      = fq_ff;
      valid_in   = valid_ff;
      ok_in      = ok_ff;
      ov_in      = ov_ff;
      oc_in      = oc_ff;
      op_in      = op_ff;
      of_in      = of_ff;
      od_in      = od_ff;
      omax_in    = omax_ff;
      omin_in    = omin_ff;
      pop        = 1'b0;

      if (csr_valid) begin
         nominal_in = csr_wdata;
      end
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               frame_in = head;
               step_in  = '0;
               if (head.crc_ok) begin
                  if (head.voltage_word > max_ff) begin
                     max_in = head.voltage_word;
                  end
                  if (head.voltage_word < min_ff) begin
                     min_in = head.voltage_word;
                  end
                  state_in = S_SCALE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCALE: begin
            if (step_ff == 6'd0) begin
               diff_in = (frame_ff.voltage_word >= nominal_ff)
                       ? frame_ff.voltage_word - nominal_ff
                       : nominal_ff - frame_ff.voltage_word;
            end
            prod_in = {32'd0, scale_op} * {32'd0, RECIP_100};
            case (step_ff)
               6'd1:    vq_in = prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
               6'd2:    cq_in = prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
               6'd3:    fq_in = prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
               default: ;
            endcase
            if (step_ff == 6'd3) begin
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_MUL: begin
            num_in   = NUM_W'(diff_ff) * NUM_W'(SCALE);
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (trial >= {1'b0, frame_ff.voltage_word}) begin
               rem_in = 32'(trial - {1'b0, frame_ff.voltage_word});
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            if (step_ff == DIV_LAST_STEP) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               valid_in = 1'b1;
               ok_in    = frame_ff.crc_ok;
               if (frame_ff.crc_ok) begin
                  ov_in   = vq_ff;
                  oc_in   = cq_ff;
                  op_in   = frame_ff.power_word;
                  of_in   = fq_ff;
                  od_in   = (frame_ff.voltage_word == '0 || num_ff[NUM_W-1:32] != '0)
                          ? '1 : num_ff[31:0];
                  omax_in = max_ff;
                  omin_in = min_ff;
               end else begin
                  ov_in   = '0;
                  oc_in   = '0;
                  op_in   = '0;
                  of_in   = '0;
                  od_in   = '0;
                  omax_in = '0;
                  omin_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      diff_ff  <= diff_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      vq_ff    <= vq_in;
      cq_ff    <= cq_in;
      fq_ff    <= fq_in;
      ok_ff    <= ok_in;
      ov_ff    <= ov_in;
      oc_ff    <= oc_in;
      op_ff    <= op_in;
      of_ff    <= of_in;
      od_ff    <= od_in;
      omax_ff  <= omax_in;
      omin_ff  <= omin_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         nominal_ff <= NOMINAL_RESET;
         max_ff     <= MAX_RESET;
         min_ff     <= MIN_RESET;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         nominal_ff <= nominal_in;
         max_ff     <= max_in;
         min_ff     <= min_in;
         valid_ff   <= valid_in;
      end
   end

endmodule

`default_nettype wire

[hdl/meter_frame_crc_decoder_unit.sv]
// Top level of the meter frame CRC decoder: front end, frame queue, back end.
// Depends on mfcd_pkg, mfcd_front, mfcd_queue and mfcd_back.
//
//   channel  direction  handshake            transaction
//   req_     in         req_valid/req_stall  one received byte
//   rsp_     out        rsp_valid/rsp_stall  one result per 37-byte frame
//   csr_     in         csr_valid/csr_ready  nominal voltage write
//
// A byte is taken in one cycle; the CRC and word capture run as it arrives.
// Each frame with a good CRC then passes through the back end's three reciprocal
// multiplies for the /100 fields and a 39-step shift-subtract divider.
// req_stall rises only while the frame queue is full; results wait in the
// output register while the back end goes on. Reset is synchronous.
`default_nettype none

module meter_frame_crc_decoder_unit #(
   parameter int QUEUE_DEPTH = mfcd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_crc_ok,
   output logic [15:0] rsp_voltage,
   output logic [15:0] rsp_current,
   output logic [31:0] rsp_power_hundredths,
   output logic [15:0] rsp_frequency,
   output logic [31:0] rsp_deviation_percent,
   output logic [31:0] rsp_voltage_max,
   output logic [31:0] rsp_voltage_min,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [31:0] csr_wdata
);
   import mfcd_pkg::*;

   frame_type push_frame;
   frame_type head;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;

   mfcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_frame  (push_frame)
   );

   mfcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   mfcd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_wdata             (csr_wdata),
      .queue_empty           (queue_empty),
      .head                  (head),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_crc_ok            (rsp_crc_ok),
      .rsp_voltage           (rsp_voltage),
      .rsp_current           (rsp_current),
      .rsp_power_hundredths  (rsp_power_hundredths),
      .rsp_frequency         (rsp_frequency),
      .rsp_deviation_percent (rsp_deviation_percent),
      .rsp_voltage_max       (rsp_voltage_max),
      .rsp_voltage_min       (rsp_voltage_min)
   );

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for meter_frame_crc_decoder_unit: streams 37-byte meter frames, checks results.
// A scoreboard class decodes the same byte stream to predict results. Needs only the RTL.

module tb_top;

   localparam int FRAME_BYTES  = 37;
   localparam int CRC_BYTES    = 35;
   localparam int VOLT_AT      = 3;
   localparam int CURR_AT      = 7;
   localparam int POWER_AT     = 11;
   localparam int FREQ_AT      = 31;
   localparam int HOLD_AT      = 17;
   localparam int DRAIN_CYCLES = 200;
   localparam int TIMEOUT_NS   = 3_000_000;
   localparam int MAX_PRINTS   = 40;

   localparam logic [15:0] CRC_START       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REV    = 16'hA001;
   localparam logic [31:0] NOMINAL_DEFAULT = 32'd2200000;
   localparam logic [31:0] MIN_START       = 32'd3800000;
   localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

   typedef enum int {FRAME_GOOD, FRAME_BAD_LO, FRAME_BAD_HI, FRAME_FLIP, FRAME_NOISE}
      frame_kind_type;

   typedef struct packed {
      logic        crc_ok;
      logic [15:0] voltage;
      logic [15:0] current;
      logic [31:0] power;
      logic [15:0] frequency;
      logic [31:0] deviation;
      logic [31:0] vmax;
      logic [31:0] vmin;
   } meter_result_type;

   class frame_scoreboard;
      logic [31:0]      nominal;
      logic [5:0]       pos;
      logic [15:0]      crc;
      logic [31:0]      volt_w, curr_w, pwr_w, freq_w;
      logic [7:0]       crc_lo;
      logic [31:0]      vmax, vmin;
      meter_result_type expected_frames[$];
      int               errors, good_seen, bad_seen, byte_total;

      function new();
         nominal    = NOMINAL_DEFAULT;
         pos        = '0;
         crc        = CRC_START;
         volt_w     = '0;
         curr_w     = '0;
         pwr_w      = '0;
         freq_w     = '0;
         crc_lo     = '0;
         vmax       = '0;
         vmin       = MIN_START;
         errors     = 0;
         good_seen  = 0;
         bad_seen   = 0;
         byte_total = 0;
      endfunction

      static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c ^ {8'h00, b};
         for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REV) : (r >> 1);
         end
         return r;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
      endtask

      function void note_byte(logic [7:0] b);
         meter_result_type res;
         logic [63:0]      diff, quot;
         byte_total++;
         if (pos < CRC_BYTES) begin
            crc = crc16_step(crc, b);
         end
         if (pos >= VOLT_AT && pos < VOLT_AT + 4) begin
            volt_w = {volt_w[23:0], b};
         end else if (pos >= CURR_AT && pos < CURR_AT + 4) begin
            curr_w = {curr_w[23:0], b};
         end else if (pos >= POWER_AT && pos < POWER_AT + 4) begin
            pwr_w = {pwr_w[23:0], b};
         end else if (pos >= FREQ_AT && pos < FREQ_AT + 4) begin
            freq_w = {freq_w[23:0], b};
         end else if (pos == CRC_BYTES) begin
            crc_lo = b;
         end
         if (pos != FRAME_BYTES - 1) begin
            pos++;
            return;
         end
         res = '0;
         if (crc_lo == crc[7:0] && b == crc[15:8]) begin
            if (volt_w > vmax) begin
               vmax = volt_w;
            end
            if (volt_w < vmin) begin
               vmin = volt_w;
            end
            if (volt_w == 0) begin
               quot = {32'd0, ALL_ONES};
            end else begin
               diff = (volt_w >= nominal) ? {32'd0, volt_w - nominal} : {32'd0, nominal - volt_w};
               quot = (diff * 64'd100) / {32'd0, volt_w};
               if (quot > {32'd0, ALL_ONES}) begin
                  quot = {32'd0, ALL_ONES};
               end
            end
            res.crc_ok    = 1'b1;
            res.voltage   = 16'(volt_w / 32'd100);
            res.current   = 16'(curr_w / 32'd100);
            res.power     = pwr_w;
            res.frequency = 16'(freq_w / 32'd100);
            res.deviation = quot[31:0];
            res.vmax      = vmax;
            res.vmin      = vmin;
         end
         expected_frames.push_back(res);
         pos = '0;
         crc = CRC_START;
      endfunction

      task field_match(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            report($sformatf("%s: expected %0h, got %0h", name, want, got));
         end
      endtask

      task check_result(meter_result_type got);
         meter_result_type want;
         if (expected_frames.size() == 0) begin
            report($sformatf("result with no frame pending, crc_ok=%0b", got.crc_ok));
            return;
         end
         want = expected_frames.pop_front();
         field_match("crc_ok", want.crc_ok, got.crc_ok);
         field_match("voltage", want.voltage, got.voltage);
         field_match("current", want.current, got.current);
         field_match("power_hundredths", want.power, got.power);
         field_match("frequency", want.frequency, got.frequency);
         field_match("deviation_percent", want.deviation, got.deviation);
         field_match("voltage_max", want.vmax, got.vmax);
         field_match("voltage_min", want.vmin, got.vmin);
         if (want.crc_ok) begin
            good_seen++;
         end else begin
            bad_seen++;
         end
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        csr_valid   = 1'b0;
   logic [31:0] csr_wdata   = 32'd0;

   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_crc_ok;
   logic [15:0] rsp_voltage;
   logic [15:0] rsp_current;
   logic [31:0] rsp_power_hundredths;
   logic [15:0] rsp_frequency;
   logic [31:0] rsp_deviation_percent;
   logic [31:0] rsp_voltage_max;
   logic [31:0] rsp_voltage_min;
   logic        csr_ready;

   frame_scoreboard sb = new();
   logic [7:0]      frame_buf [0:FRAME_BYTES-1];
   int              gap_pct = 0;
   int              stall_pct = 0;
   int              stall_left = 0;
   int              nominal_writes = 0;

   meter_frame_crc_decoder_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_crc_ok            (rsp_crc_ok),
      .rsp_voltage           (rsp_voltage),
      .rsp_current           (rsp_current),
      .rsp_power_hundredths  (rsp_power_hundredths),
      .rsp_frequency         (rsp_frequency),
      .rsp_deviation_percent (rsp_deviation_percent),
      .rsp_voltage_max       (rsp_voltage_max),
      .rsp_voltage_min       (rsp_voltage_min),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result('{rsp_crc_ok, rsp_voltage, rsp_current, rsp_power_hundredths,
                              rsp_frequency, rsp_deviation_percent, rsp_voltage_max,
                              rsp_voltage_min});
         end
         if (csr_valid && csr_ready) begin
            sb.nominal = csr_wdata;
            nominal_writes++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Drop valid, wait for every pending result, then hold for the extra cycles.
   task automatic settle(int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_nominal(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_byte(logic [7:0] b);
      int n;
      if ($urandom_range(0, 99) < gap_pct) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(frame_kind_type kind, logic [31:0] v, logic [31:0] c,
                             logic [31:0] p, logic [31:0] f, bit hold_mid);
      logic [15:0] crc;
      int          idx;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame_buf[i] = 8'($urandom);
      end
      if (kind != FRAME_NOISE) begin
         for (int i = 0; i < 4; i++) begin
            frame_buf[VOLT_AT + i]  = v[31 - 8*i -: 8];
            frame_buf[CURR_AT + i]  = c[31 - 8*i -: 8];
            frame_buf[POWER_AT + i] = p[31 - 8*i -: 8];
            frame_buf[FREQ_AT + i]  = f[31 - 8*i -: 8];
         end
         crc = CRC_START;
         for (int i = 0; i < CRC_BYTES; i++) begin
            crc = frame_scoreboard::crc16_step(crc, frame_buf[i]);
         end
         frame_buf[CRC_BYTES]     = crc[7:0];
         frame_buf[CRC_BYTES + 1] = crc[15:8];
      end
      case (kind)
         FRAME_BAD_LO: frame_buf[CRC_BYTES] ^= 8'($urandom_range(1, 255));
         FRAME_BAD_HI: frame_buf[CRC_BYTES + 1] ^= 8'($urandom_range(1, 255));
         FRAME_FLIP: begin
            idx = $urandom_range(0, FRAME_BYTES - 1);
            frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
         end
         default: ;
      endcase
      for (int i = 0; i < FRAME_BYTES; i++) begin
         send_byte(frame_buf[i]);
         if (hold_mid && i == HOLD_AT) begin
            settle(0);
         end
      end
   endtask

   function automatic logic [31:0] pick_voltage();
      case ($urandom_range(0, 9))
         0:          return 32'd0;
         1:          return $urandom_range(1, 1000);
         2, 3, 4, 5: return sb.nominal + $urandom_range(0, 400000) - 32'd200000;
         6:          return ALL_ONES - $urandom_range(0, 1000);
         default:    return $urandom;
      endcase
   endfunction

   task automatic run_random(int frames, int gap_max, int stall_max, bit hold_one);
      int             r;
      frame_kind_type kind;
      for (int n = 0; n < frames; n++) begin
         gap_pct   = $urandom_range(0, gap_max);
         stall_pct = $urandom_range(0, stall_max);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            kind = FRAME_GOOD;
         end else if (r < 76) begin
            kind = FRAME_BAD_LO;
         end else if (r < 82) begin
            kind = FRAME_BAD_HI;
         end else if (r < 91) begin
            kind = FRAME_FLIP;
         end else begin
            kind = FRAME_NOISE;
         end
         send_frame(kind, pick_voltage(), $urandom,
                    $urandom, ($urandom_range(0, 1) != 0) ? $urandom_range(4500, 6500) : $urandom,
                    hold_one && n == 3);
      end
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      gap_pct   = 30;
      stall_pct = 25;
      send_frame(FRAME_GOOD, 32'd5000000, 32'd0, ALL_ONES, 32'd5000, 1'b0);
      send_frame(FRAME_GOOD, NOMINAL_DEFAULT, ALL_ONES, 32'd0, ALL_ONES, 1'b0);
      send_frame(FRAME_GOOD, 32'd0, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_BAD_LO, 32'd1234567, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_BAD_HI, 32'd1234567, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_FLIP, $urandom, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_GOOD, ALL_ONES, $urandom, $urandom, $urandom, 1'b0);
      settle(DRAIN_CYCLES);

      write_nominal(ALL_ONES);
      send_frame(FRAME_GOOD, 32'd1, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_GOOD, ALL_ONES, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_GOOD, 32'h8000_0000, $urandom, $urandom, $urandom, 1'b0);
      settle(DRAIN_CYCLES);

      write_nominal(32'd0);
      send_frame(FRAME_GOOD, 32'd0, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_GOOD, 32'd12345, $urandom, $urandom, $urandom, 1'b0);
      send_frame(FRAME_NOISE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      settle(DRAIN_CYCLES);

      write_nominal($urandom);
      run_random(10, 40, 40, 1'b1);
      settle(DRAIN_CYCLES);

      write_nominal(NOMINAL_DEFAULT);
      run_random(10, 40, 40, 1'b0);
      settle(DRAIN_CYCLES);

      write_nominal($urandom_range(0, 5000000));
      run_random(9, 40, 40, 1'b0);
      run_random(8, 0, 0, 1'b0);
      settle(DRAIN_CYCLES);

      if (sb.expected_frames.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.expected_frames.size()));
      end
      $display("Covered %0d bytes over %0d nominal voltage settings.",
               sb.byte_total, nominal_writes + 1);
      $display("Checked %0d frames with a good CRC and %0d rejected frames, %0d mismatches.",
               sb.good_seen, sb.bad_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/mfcd_pkg.sv
hdl/mfcd_front.sv
hdl/mfcd_queue.sv
hdl/mfcd_back.sv
hdl/meter_frame_crc_decoder_unit.sv
test/tb_top.sv
